### design/gaussian_downsample_to_gray_macros.svh
// Assertion macros used by the port-level checker of the downsampler
`ifndef GAUSSIAN_DOWNSAMPLE_TO_GRAY_MACROS_SVH
`define GAUSSIAN_DOWNSAMPLE_TO_GRAY_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define GDTG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdtg assertion failed");

// consequent must hold in the cycle after the antecedent
`define GDTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdtg assertion failed");

// consequent must hold in the cycle after reset is seen high
`define GDTG_ASSERT_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("gdtg assertion failed");

`endif

### design/gdtg_pkg.sv
// Types and constants shared by the downsampler modules
`default_nettype none

package gdtg_pkg;

   localparam int CSR_BITS    = 12;
   localparam int PIXEL_BITS  = 8;
   localparam int LUMA_BITS   = 24;
   localparam int VSUM_BITS   = 26;
   localparam int SUM_BITS    = 28;
   localparam int GRAY_BITS   = 8;
   localparam int GRAY_SHIFT  = 20;

   // BT.601 weights in Q16
   localparam logic [15:0] LUMA_R = 16'd19595;
   localparam logic [15:0] LUMA_G = 16'd38470;
   localparam logic [15:0] LUMA_B = 16'd7471;

   localparam logic [CSR_BITS-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CSR_BITS-1:0] HEIGHT_RESET = 12'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      CSR_SOURCE_WIDTH  = 1'b0,
      CSR_SOURCE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [LUMA_BITS-1:0] older;
      logic [LUMA_BITS-1:0] newer;
   } line_pair_type;

   typedef struct packed {
      logic emit;
      logic border;
      logic row_end;
      logic frame_end;
   } pixel_flags_type;

   typedef struct packed {
      logic [LUMA_BITS-1:0] top;
      logic [LUMA_BITS-1:0] mid;
      logic [LUMA_BITS-1:0] cur;
      pixel_flags_type      flags;
   } column_entry_type;

endpackage

`default_nettype wire

### design/gdtg_channels.sv
// Request and response channel interfaces of the downsampler
`default_nettype none

interface gdtg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;

   modport source (output valid, output blue, output green, output red, input ready);
   modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface gdtg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] gray;
   logic       row_end;
   logic       frame_end;

   modport source (output valid, output gray, output row_end, output frame_end, input ready);
   modport sink   (input valid, input gray, input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

### design/gdtg_queue.sv
// Short queue of classified columns between front and back
`default_nettype none

module gdtg_queue (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  gdtg_pkg::column_entry_type           push_entry,
   input  wire logic                            pop,
   output gdtg_pkg::column_entry_type           head_entry,
   output logic                                 not_empty,
   output logic [gdtg_pkg::QCOUNT_BITS-1:0]     count
);

   gdtg_pkg::column_entry_type            slot_ff [gdtg_pkg::QUEUE_DEPTH];
   logic [gdtg_pkg::QPTR_BITS-1:0]        head_ff, head_in;
   logic [gdtg_pkg::QPTR_BITS-1:0]        tail_ff, tail_in;
   logic [gdtg_pkg::QCOUNT_BITS-1:0]      count_ff, count_in;

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_entry;
      end
   end

   assign head_entry = slot_ff[head_ff];
   assign not_empty  = (count_ff != '0);
   assign count      = count_ff;

endmodule

`default_nettype wire

### design/gdtg_front.sv
// Front end: size registers, position counters, line buffer, luma and classification
`default_nettype none

module gdtg_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   gdtg_req_if.sink                               req,
   input  wire logic                              csr_write_enable,
   input  gdtg_pkg::csr_index_type                csr_index,
   input  wire logic [gdtg_pkg::CSR_BITS-1:0]     csr_write_data,
   input  wire logic [gdtg_pkg::QCOUNT_BITS-1:0]  queue_count,
   output logic                                   push,
   output gdtg_pkg::column_entry_type             push_entry
);

   localparam int CB   = $clog2(MAX_WIDTH);
   localparam int RB   = $clog2(MAX_HEIGHT);
   localparam int WB   = $clog2(MAX_WIDTH + 1);
   localparam int HB   = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP = (WB > gdtg_pkg::CSR_BITS) ? WB : gdtg_pkg::CSR_BITS;
   localparam int HCMP = (HB > gdtg_pkg::CSR_BITS) ? HB : gdtg_pkg::CSR_BITS;

   logic [gdtg_pkg::CSR_BITS-1:0]    width_ff;
   logic [gdtg_pkg::CSR_BITS-1:0]    height_ff;
   logic [WCMP-1:0]                  width_raw;
   logic [HCMP-1:0]                  height_raw;
   logic [WB-1:0]                    width_eff;
   logic [HB-1:0]                    height_eff;

   logic [CB-1:0]                    col_ff, col_in;
   logic [RB-1:0]                    row_ff, row_in;
   logic [WB-1:0]                    col_ext;
   logic [HB-1:0]                    row_ext;
   logic                             accept;
   logic                             col_ok;
   logic                             row_ok;
   logic                             last_col;
   logic                             last_row;
   gdtg_pkg::pixel_flags_type        flags;

   logic                             b_valid_ff;
   logic                             b_in_range_ff;
   logic [CB-1:0]                    b_addr_ff;
   logic [gdtg_pkg::PIXEL_BITS-1:0]  b_blue_ff;
   logic [gdtg_pkg::PIXEL_BITS-1:0]  b_green_ff;
   logic [gdtg_pkg::PIXEL_BITS-1:0]  b_red_ff;
   gdtg_pkg::pixel_flags_type        b_flags_ff;
   gdtg_pkg::line_pair_type          b_line_ff;
   gdtg_pkg::line_pair_type          line_mem [MAX_WIDTH];
   logic [gdtg_pkg::LUMA_BITS-1:0]   cur_luma;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gdtg_pkg::WIDTH_RESET;
         height_ff <= gdtg_pkg::HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            gdtg_pkg::CSR_SOURCE_WIDTH:  width_ff  <= csr_write_data;
            gdtg_pkg::CSR_SOURCE_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // clamp sizes to 2..MAX
   always_comb begin
      width_raw  = WCMP'(width_ff);
      height_raw = HCMP'(height_ff);
      if (width_raw < WCMP'(2)) begin
         width_eff = WB'(2);
      end else if (width_raw > WCMP'(MAX_WIDTH)) begin
         width_eff = WB'(MAX_WIDTH);
      end else begin
         width_eff = WB'(width_raw);
      end
      if (height_raw < HCMP'(2)) begin
         height_eff = HB'(2);
      end else if (height_raw > HCMP'(MAX_HEIGHT)) begin
         height_eff = HB'(MAX_HEIGHT);
      end else begin
         height_eff = HB'(height_raw);
      end
   end

   // take a request only when the queue has a slot for it and the one in flight
   assign req.ready = (queue_count + gdtg_pkg::QCOUNT_BITS'(b_valid_ff))
                      < gdtg_pkg::QCOUNT_BITS'(gdtg_pkg::QUEUE_DEPTH);
   assign accept    = req.valid && req.ready;

   // classify the position of the incoming pixel
   always_comb begin
      col_ext  = WB'(col_ff);
      row_ext  = HB'(row_ff);
      col_ok   = col_ext < width_eff;
      row_ok   = row_ext < height_eff;
      last_col = ((col_ext >> 1) + 1'b1) == (width_eff >> 1);
      last_row = ((row_ext >> 1) + 1'b1) == (height_eff >> 1);
      flags.emit      = row_ff[0] && col_ff[0] && col_ok && row_ok;
      flags.border    = ((row_ext >> 1) == '0) || ((col_ext >> 1) == '0)
                        || last_col || last_row;
      flags.row_end   = last_col;
      flags.frame_end = last_col && last_row;
   end

   // advance the position, wrapping anything at or past the size
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if ((col_ext + 1'b1) >= width_eff) begin
         col_in = '0;
         row_in = ((row_ext + 1'b1) >= height_eff) ? '0 : RB'(row_ext + 1'b1);
      end else begin
         col_in = CB'(col_ext + 1'b1);
         if (!row_ok) begin
            row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_in_range_ff <= col_ok;
         b_addr_ff     <= col_ff;
         b_blue_ff     <= req.blue;
         b_green_ff    <= req.green;
         b_red_ff      <= req.red;
         b_flags_ff    <= flags;
      end
   end

   assign cur_luma = gdtg_pkg::LUMA_BITS'(b_red_ff)   * gdtg_pkg::LUMA_BITS'(gdtg_pkg::LUMA_R)
                   + gdtg_pkg::LUMA_BITS'(b_green_ff) * gdtg_pkg::LUMA_BITS'(gdtg_pkg::LUMA_G)
                   + gdtg_pkg::LUMA_BITS'(b_blue_ff)  * gdtg_pkg::LUMA_BITS'(gdtg_pkg::LUMA_B);

   // line buffer: read on accept, shift the column down one row in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         b_line_ff <= line_mem[col_ff];
      end
      if (b_valid_ff && b_in_range_ff) begin
         line_mem[b_addr_ff] <= '{older: b_line_ff.newer, newer: cur_luma};
      end
   end

   assign push             = b_valid_ff;
   assign push_entry.top   = b_in_range_ff ? b_line_ff.older : '0;
   assign push_entry.mid   = b_in_range_ff ? b_line_ff.newer : '0;
   assign push_entry.cur   = cur_luma;
   assign push_entry.flags = b_flags_ff;

endmodule

`default_nettype wire

### design/gdtg_back.sv
// Back end: vertical sums, horizontal window and the response register
`default_nettype none

module gdtg_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  gdtg_pkg::column_entry_type    head_entry,
   input  wire logic                     not_empty,
   output logic                          pop,
   gdtg_rsp_if.source                    rsp
);

   logic                              advance;
   logic [gdtg_pkg::VSUM_BITS-1:0]    head_vsum;
   logic                              v_valid_ff;
   logic [gdtg_pkg::VSUM_BITS-1:0]    v_ff;
   gdtg_pkg::pixel_flags_type         v_flags_ff;
   logic [gdtg_pkg::VSUM_BITS-1:0]    win1_ff;
   logic [gdtg_pkg::VSUM_BITS-1:0]    win2_ff;
   logic [gdtg_pkg::SUM_BITS-1:0]     total;
   logic                              rsp_valid_ff;
   logic [gdtg_pkg::GRAY_BITS-1:0]    gray_ff, gray_in;
   logic                              row_end_ff;
   logic                              frame_end_ff;

   // move on whenever the response register is free or being taken
   assign advance = !rsp_valid_ff || rsp.ready;
   assign pop     = advance && not_empty;

   assign head_vsum = gdtg_pkg::VSUM_BITS'(head_entry.top)
                    + (gdtg_pkg::VSUM_BITS'(head_entry.mid) << 1)
                    + gdtg_pkg::VSUM_BITS'(head_entry.cur);

   assign total = gdtg_pkg::SUM_BITS'(win2_ff)
                + (gdtg_pkg::SUM_BITS'(win1_ff) << 1)
                + gdtg_pkg::SUM_BITS'(v_ff);

   assign gray_in = v_flags_ff.border ? '0
                  : total[gdtg_pkg::GRAY_SHIFT +: gdtg_pkg::GRAY_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win1_ff      <= '0;
         win2_ff      <= '0;
      end else if (advance) begin
         v_valid_ff   <= not_empty;
         rsp_valid_ff <= v_valid_ff && v_flags_ff.emit;
         if (v_valid_ff) begin
            win2_ff <= win1_ff;
            win1_ff <= v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v_ff         <= head_vsum;
         v_flags_ff   <= head_entry.flags;
         gray_ff      <= gray_in;
         row_end_ff   <= v_flags_ff.row_end;
         frame_end_ff <= v_flags_ff.frame_end;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.gray      = gray_ff;
   assign rsp.row_end   = row_end_ff;
   assign rsp.frame_end = frame_end_ff;

endmodule

`default_nettype wire

### design/gaussian_downsample_to_gray.sv
// Top level of the Gaussian blur, luma and downsample-by-two block
//
//   channel   direction  handshake          payload
//   req_if    in         valid/ready        blue, green, red (8 bits each)
//   rsp_if    out        valid/ready        gray (8), row_end, frame_end
//   csr_*     in         write enable only  index (1), data (12)
//
// Sustained rate is one pixel per cycle while rsp_if is not stalled; the line
// buffer is read once and written once per pixel, which sets that figure.
// A response passes the pixel register, queue, v_ff and gray_ff in turn.
// A stalled response holds the back end; the 4-entry queue then fills and
// req_if.ready drops until a slot frees up.
// Synchronous reset clears counters, window and queue; the line buffer is not
// cleared and needs no clearing pass.
`default_nettype none

module gaussian_downsample_to_gray #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   gdtg_req_if.sink                            req_if,
   gdtg_rsp_if.source                          rsp_if,
   input  wire logic                           csr_write_enable,
   input  gdtg_pkg::csr_index_type             csr_index,
   input  wire logic [gdtg_pkg::CSR_BITS-1:0]  csr_write_data
);

   logic                                  push;
   gdtg_pkg::column_entry_type            push_entry;
   logic                                  pop;
   gdtg_pkg::column_entry_type            head_entry;
   logic                                  not_empty;
   logic [gdtg_pkg::QCOUNT_BITS-1:0]      queue_count;

   gdtg_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_count      (queue_count),
      .push             (push),
      .push_entry       (push_entry)
   );

   gdtg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .count      (queue_count)
   );

   gdtg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .pop        (pop),
      .rsp        (rsp_if)
   );

endmodule

`default_nettype wire

### design/gdtg_checker.sv
// Port-level checker for the downsampler, bound to the top level
`default_nettype none

`include "gaussian_downsample_to_gray_macros.svh"

module gdtg_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_gray,
   input wire logic       rsp_row_end,
   input wire logic       rsp_frame_end
);

   logic       rsp_stalled;
   logic [9:0] rsp_data;

   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign rsp_data    = {rsp_gray, rsp_row_end, rsp_frame_end};

   // a frame always closes at the end of a row
   `GDTG_ASSERT_SAME(frame_end_on_row_end, clock, reset, rsp_valid && rsp_frame_end, rsp_row_end)

   // nothing is offered right after reset
   `GDTG_ASSERT_RESET(quiet_after_reset, clock, reset, !rsp_valid)

   // hold a stalled response
   `GDTG_ASSERT_NEXT(hold_stalled_rsp, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_data))

endmodule

bind gaussian_downsample_to_gray gdtg_checker u_gdtg_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_gray      (rsp_if.gray),
   .rsp_row_end   (rsp_if.row_end),
   .rsp_frame_end (rsp_if.frame_end)
);

`default_nettype wire

### bench/tb_gaussian_downsample_to_gray.sv
// Self-checking bench for the Gaussian blur, luma and downsample-by-two block
`default_nettype none

module tb_gaussian_downsample_to_gray;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH     = 2048;
   localparam int MAX_HEIGHT    = 2048;
   localparam int RANDOM_PIXELS = 1500;
   localparam int WIDE_PIXELS   = 256;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [gdtg_pkg::GRAY_BITS-1:0] gray;
      logic                           row_end;
      logic                           frame_end;
   } gray_pixel_type;

   typedef enum logic [1:0] {
      STEP_WIDTH,
      STEP_HEIGHT,
      STEP_PIXELS
   } step_kind_type;

   // amount is the register value or the number of identical pixels; a typed
   // result applies to the last pixel of the step
   typedef struct packed {
      step_kind_type  kind;
      logic [11:0]    amount;
      logic [7:0]     blue;
      logic [7:0]     green;
      logic [7:0]     red;
      logic           typed;
      gray_pixel_type result;
   } directed_step_type;

   localparam directed_step_type DIRECTED_STEPS [14] = '{
      // 2x3 frame: width clamps up to 2, the odd last row stays silent
      '{STEP_WIDTH,  12'd0, 8'd0,   8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
      '{STEP_HEIGHT, 12'd3, 8'd0,   8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
      '{STEP_PIXELS, 12'd1, 8'd0,   8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
      '{STEP_PIXELS, 12'd1, 8'd255, 8'd255, 8'd255, 1'b0, '{8'd0,   1'b0, 1'b0}},
      '{STEP_PIXELS, 12'd1, 8'd255, 8'd0,   8'd255, 1'b0, '{8'd0,   1'b0, 1'b0}},
      '{STEP_PIXELS, 12'd1, 8'd0,   8'd255, 8'd0,   1'b1, '{8'd0,   1'b1, 1'b1}},
      '{STEP_PIXELS, 12'd2, 8'd128, 8'd64,  8'd32,  1'b0, '{8'd0,   1'b0, 1'b0}},
      // 6x6 white frame up to the first inner output
      '{STEP_WIDTH,  12'd6, 8'd0,   8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
      '{STEP_HEIGHT, 12'd6, 8'd0,   8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
      '{STEP_PIXELS, 12'd8, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   1'b0, 1'b0}},
      '{STEP_PIXELS, 12'd2, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   1'b0, 1'b0}},
      '{STEP_PIXELS, 12'd2, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   1'b1, 1'b0}},
      '{STEP_PIXELS, 12'd8, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   1'b0, 1'b0}},
      '{STEP_PIXELS, 12'd2, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 1'b0, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   gdtg_req_if req_if ();
   gdtg_rsp_if rsp_if ();

   logic                          csr_write_enable;
   gdtg_pkg::csr_index_type       csr_index;
   logic [gdtg_pkg::CSR_BITS-1:0] csr_write_data;

   gaussian_downsample_to_gray #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // predictor state
   int unsigned   older_luma [MAX_WIDTH];
   int unsigned   newer_luma [MAX_WIDTH];
   int unsigned   column_luma [6];
   int unsigned   col_pos;
   int unsigned   row_pos;
   logic [11:0]   width_reg;
   logic [11:0]   height_reg;

   gray_pixel_type expected_grays [$];
   int unsigned   error_count;
   int unsigned   grays_checked;
   int unsigned   pixels_sent;
   int unsigned   size_settings;
   int unsigned   cycle_count;
   int unsigned   idle_pct;
   int unsigned   stall_pct;

   function automatic int unsigned clamp_dim(input logic [11:0] value, input int unsigned limit);
      if (value < 12'd2)
         return 2;
      if (value > limit)
         return limit;
      return value;
   endfunction

   // advance the predictor by one source pixel; returns 1 when a gray pixel is due
   function automatic bit blur_pixel(input logic [7:0] blue, green, red,
                                     output gray_pixel_type px);
      int unsigned w;
      int unsigned h;
      int unsigned cur;
      int unsigned top;
      int unsigned mid;
      int unsigned sum;
      int unsigned out_col;
      int unsigned out_row;
      bit          last_col;
      bit          last_row;
      bit          emit;
      w   = clamp_dim(width_reg, MAX_WIDTH);
      h   = clamp_dim(height_reg, MAX_HEIGHT);
      cur = int'(gdtg_pkg::LUMA_R) * red + int'(gdtg_pkg::LUMA_G) * green
          + int'(gdtg_pkg::LUMA_B) * blue;
      top = 0;
      mid = 0;
      emit = 1'b0;
      px = '0;
      if (col_pos < w) begin
         top = older_luma[col_pos];
         mid = newer_luma[col_pos];
         older_luma[col_pos] = mid;
         newer_luma[col_pos] = cur;
      end
      if (row_pos[0] && col_pos[0] && row_pos < h && col_pos < w) begin
         out_row  = row_pos >> 1;
         out_col  = col_pos >> 1;
         last_col = (out_col + 1 == (w >> 1));
         last_row = (out_row + 1 == (h >> 1));
         if (out_row != 0 && out_col != 0 && !last_col && !last_row) begin
            sum = column_luma[0] + 2 * column_luma[3] + top
                + 2 * (column_luma[1] + 2 * column_luma[4] + mid)
                + column_luma[2] + 2 * column_luma[5] + cur;
            px.gray = sum[gdtg_pkg::GRAY_SHIFT +: gdtg_pkg::GRAY_BITS];
         end
         px.row_end   = last_col;
         px.frame_end = last_col && last_row;
         emit = 1'b1;
      end
      column_luma[0] = column_luma[3];
      column_luma[1] = column_luma[4];
      column_luma[2] = column_luma[5];
      column_luma[3] = top;
      column_luma[4] = mid;
      column_luma[5] = cur;
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
         if (row_pos >= h)
            row_pos = 0;
      end
      return emit;
   endfunction

   // called and left at a falling edge
   task automatic send_pixel(input logic [7:0] blue, green, red,
                             input bit use_typed, input gray_pixel_type typed_px);
      gray_pixel_type px;
      bit             emitted;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      emitted = blur_pixel(blue, green, red, px);
      if (use_typed)
         expected_grays = {expected_grays, typed_px};
      else if (emitted)
         expected_grays = {expected_grays, px};
      req_if.valid <= 1'b1;
      req_if.blue  <= blue;
      req_if.green <= green;
      req_if.red   <= red;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic send_random_pixel();
      case ($urandom_range(0, 7))
         0: send_pixel(8'd0, 8'd0, 8'd0, 1'b0, '0);
         1: send_pixel(8'd255, 8'd255, 8'd255, 1'b0, '0);
         default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      endcase
   endtask

   // hold off until the block is idle, then write one size register
   task automatic write_size(input gdtg_pkg::csr_index_type index, input logic [11:0] value);
      req_if.valid <= 1'b0;
      while (expected_grays.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == gdtg_pkg::CSR_SOURCE_WIDTH)
         width_reg = value;
      else
         height_reg = value;
   endtask

   task automatic finish_frame();
      while (col_pos != 0 || row_pos != 0)
         send_random_pixel();
   endtask

   always @(posedge clock) begin : check_gray
      gray_pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_grays.size() == 0) begin
            $error("unexpected gray pixel %0d", rsp_if.gray);
            error_count++;
         end else begin
            want = expected_grays.pop_front();
            grays_checked++;
            if (rsp_if.gray !== want.gray) begin
               $error("gray mismatch: expected %0d, actual %0d", want.gray, rsp_if.gray);
               error_count++;
            end
            if (rsp_if.row_end !== want.row_end) begin
               $error("row_end mismatch: expected %0d, actual %0d",
                      want.row_end, rsp_if.row_end);
               error_count++;
            end
            if (rsp_if.frame_end !== want.frame_end) begin
               $error("frame_end mismatch: expected %0d, actual %0d",
                      want.frame_end, rsp_if.frame_end);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side: stall in bursts while stall_pct allows
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin : stimulus
      int unsigned random_sent;
      int unsigned phase;
      int unsigned pixel_total;
      int unsigned next_w_eff;
      logic [11:0] next_w;
      logic [11:0] next_h;
      bit          big_phase;

      req_if.valid     = 1'b0;
      req_if.blue      = '0;
      req_if.green     = '0;
      req_if.red       = '0;
      csr_write_enable = 1'b0;
      csr_index        = gdtg_pkg::CSR_SOURCE_WIDTH;
      csr_write_data   = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         older_luma[i] = 0;
         newer_luma[i] = 0;
      end
      for (int i = 0; i < 6; i++)
         column_luma[i] = 0;
      col_pos       = 0;
      row_pos       = 0;
      width_reg     = gdtg_pkg::WIDTH_RESET;
      height_reg    = gdtg_pkg::HEIGHT_RESET;
      error_count   = 0;
      grays_checked = 0;
      pixels_sent   = 0;
      size_settings = 0;
      cycle_count   = 0;
      idle_pct      = 20;
      stall_pct     = 20;
      random_sent   = 0;
      phase         = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_STEPS[s]) begin
         case (DIRECTED_STEPS[s].kind)
            STEP_WIDTH: write_size(gdtg_pkg::CSR_SOURCE_WIDTH, DIRECTED_STEPS[s].amount);
            STEP_HEIGHT: write_size(gdtg_pkg::CSR_SOURCE_HEIGHT, DIRECTED_STEPS[s].amount);
            default: begin
               for (int k = 0; k < DIRECTED_STEPS[s].amount; k++)
                  send_pixel(DIRECTED_STEPS[s].blue, DIRECTED_STEPS[s].green,
                             DIRECTED_STEPS[s].red,
                             DIRECTED_STEPS[s].typed && k == DIRECTED_STEPS[s].amount - 1,
                             DIRECTED_STEPS[s].result);
            end
         endcase
      end

      while (random_sent < RANDOM_PIXELS) begin
         big_phase = 1'b1;
         if (phase == 0) begin
            // widest register value, height clamped up to 2: start a long row
            next_w      = 12'd4095;
            next_h      = 12'd1;
            pixel_total = WIDE_PIXELS;
         end else if (phase == 1) begin
            // shrink the row mid-frame, leave the tallest frame for the next setting
            next_w      = 12'd2;
            next_h      = 12'd4095;
            pixel_total = 64;
         end else begin
            big_phase = 1'b0;
            next_w = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 1))
                                                 : 12'($urandom_range(2, 20));
            next_h = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 1))
                                                 : 12'($urandom_range(2, 14));
            pixel_total = $urandom_range(1, 2 * clamp_dim(next_w, MAX_WIDTH)
                                            * clamp_dim(next_h, MAX_HEIGHT) + 20);
            if (pixel_total > RANDOM_PIXELS - random_sent)
               pixel_total = RANDOM_PIXELS - random_sent;
         end
         if (random_sent >= RANDOM_PIXELS * 85 / 100) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         end
         // a row may only grow at a frame start; cut the frame short to get there
         next_w_eff = clamp_dim(next_w, MAX_WIDTH);
         if (next_w_eff > clamp_dim(width_reg, MAX_WIDTH)
             && (col_pos != 0 || row_pos != 0)) begin
            write_size(gdtg_pkg::CSR_SOURCE_HEIGHT, 12'd2);
            finish_frame();
         end
         write_size(gdtg_pkg::CSR_SOURCE_WIDTH, next_w);
         write_size(gdtg_pkg::CSR_SOURCE_HEIGHT, next_h);
         size_settings++;
         for (int k = 0; k < pixel_total; k++) begin
            send_random_pixel();
            if (!big_phase)
               random_sent++;
         end
         phase++;
      end

      req_if.valid <= 1'b0;
      while (expected_grays.size() != 0) @(negedge clock);
      repeat (4 * SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d source pixels over %0d size settings, checked %0d gray pixels",
               pixels_sent, size_settings, grays_checked);
      $display("Size registers ran from below the minimum to the largest value, "
               , "with mid-frame changes");
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
